// ===== rtl/ihl_pkg.sv =====
package ihl_pkg;

  localparam int unsigned RomBytesDefault       = 4096;
  localparam int unsigned MaxRecordBytesDefault = 32;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam int unsigned MinLineLength = 11;

  localparam logic [7:0] RecData = 8'h00;
  localparam logic [7:0] RecEnd  = 8'h01;
  localparam logic [7:0] RecExt  = 8'h02;

  localparam logic KindWrite  = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StEnd      = 4'd1,
    StBadLine  = 4'd2,
    StBadHex   = 4'd3,
    StExtType  = 4'd4,
    StBadType  = 4'd5,
    StTooLarge = 4'd6,
    StLenShort = 4'd7,
    StTooLong  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackFetch,
    BackEmit,
    BackStat
  } back_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] address;
    logic [7:0]  data;
    logic [3:0]  status;
    logic [11:0] program_size;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        is_data;
    status_e     status;
    logic [11:0] addr;
    logic [7:0]  len;
    logic [11:0] size;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic [7:0] offset;
    logic [7:0] data;
  } store_wr_t;

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/intel_hex_record_loader_top.sv =====
// Intel HEX record loader. Characters enter through a queue-style port: a
// request is taken on a clock edge with push high and full low. Results leave
// through a queue-style port: the oldest result sits on result_o while empty
// is low and is taken on an edge with pop high.
// A line feed, or a character marked end_of_stream, closes a record. Once
// the close is registered, the line is checked and a command enters a
// two-entry queue. The back end then emits one ROM write per data byte,
// each fetched from the byte store before it is emitted, followed by one
// status result. Every result passes from the close register through the
// command queue and the back-end states into the output register.
// An ordinary character costs one cycle while full is low. full stays high
// while a close is registered and while the queue or the back end still
// holds a record, so a line holds the input until its last result is out.
// If the receiver stalls, the output register holds its result and the back
// end waits; full then remains high until the record's last result has
// entered the output register.
// After an end record or any error the block ignores all further characters
// until reset. Reset clears all control state and the program size; no
// clearing pass is needed, and the block accepts characters at once.
module intel_hex_record_loader_top #(
  parameter int unsigned ROM_BYTES        = ihl_pkg::RomBytesDefault,
  parameter int unsigned MAX_RECORD_BYTES = ihl_pkg::MaxRecordBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  ihl_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output ihl_pkg::result_t result_o
);
  import ihl_pkg::*;

  store_wr_t store_wr;
  logic      cmd_push;
  cmd_t      cmd_in;
  logic      cmd_full;
  logic      cmd_pop;
  cmd_t      cmd_out;
  logic      cmd_empty;
  logic      back_busy;
  logic      store_busy;

  assign store_busy = !cmd_empty || back_busy;

  ihl_front #(
    .ROM_BYTES       (ROM_BYTES),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .store_busy_i(store_busy),
    .store_wr_o  (store_wr),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  ihl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cmd_push),
    .wr_cmd_i(cmd_in),
    .full_o  (cmd_full),
    .rd_en_i (cmd_pop),
    .rd_cmd_o(cmd_out),
    .empty_o (cmd_empty)
  );

  ihl_back #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .store_wr_i (store_wr),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .busy_o     (back_busy),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule

// ===== rtl/ihl_front.sv =====
module ihl_front #(
  parameter int unsigned ROM_BYTES        = ihl_pkg::RomBytesDefault,
  parameter int unsigned MAX_RECORD_BYTES = ihl_pkg::MaxRecordBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ihl_pkg::item_t     item_i,
  input  logic               store_busy_i,
  output ihl_pkg::store_wr_t store_wr_o,
  output logic               cmd_push_o,
  output ihl_pkg::cmd_t      cmd_o,
  input  logic               cmd_full_i
);
  import ihl_pkg::*;

  localparam logic [8:0]  MaxRec9   = 9'(MAX_RECORD_BYTES);
  localparam logic [17:0] RomBytes18 = 18'(ROM_BYTES);

  logic [7:0]  line_length_q, line_length_d;
  logic        phase_q, phase_d;
  logic [3:0]  high_nib_q, high_nib_d;
  logic        start_ok_q, start_ok_d;
  logic        hex_bad_q, hex_bad_d;
  logic [7:0]  pending_q, pending_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  rec_len_q, rec_len_d;
  logic [15:0] rec_addr_q, rec_addr_d;
  logic [7:0]  rec_type_q, rec_type_d;
  logic [11:0] size_q, size_d;
  logic        halted_q, halted_d;
  logic        close_q, close_d;

  logic        accept;
  status_e     status;
  logic [7:0]  present;
  logic [16:0] rec_end;
  logic [17:0] new_size;
  logic        do_close;

  assign full   = close_q || store_busy_i;
  assign accept = push && !full;

  always_comb begin
    present  = count_q - 8'd5;
    rec_end  = {1'b0, rec_addr_q} + 17'(rec_len_q);
    new_size = ({1'b0, rec_end} > 18'(size_q)) ? ({1'b0, rec_end} + 18'd2) : 18'(size_q);
    if (line_length_q < 8'(MinLineLength) || phase_q || !start_ok_q) begin
      status = StBadLine;
    end else if (hex_bad_q || sum_q != 8'd0) begin
      status = StBadHex;
    end else if (rec_type_q == RecEnd) begin
      status = StEnd;
    end else if (rec_type_q == RecExt) begin
      status = StExtType;
    end else if (rec_type_q != RecData) begin
      status = StBadType;
    end else if ({1'b0, present} > MaxRec9) begin
      status = StTooLong;
    end else if (rec_len_q > present) begin
      status = StLenShort;
    end else if (new_size >= RomBytes18 || {1'b0, rec_end} >= RomBytes18) begin
      status = StTooLarge;
    end else begin
      status = StOk;
    end
  end

  assign do_close   = close_q && !cmd_full_i;
  assign cmd_push_o = do_close;

  always_comb begin
    cmd_o.is_data = (status == StOk);
    cmd_o.status  = status;
    cmd_o.addr    = rec_addr_q[11:0];
    cmd_o.len     = rec_len_q;
    cmd_o.size    = (status == StOk) ? new_size[11:0] : size_q;
  end

  always_comb begin
    logic [7:0] ll;
    logic [7:0] n;
    logic [4:0] hx;
    logic [7:0] b;
    logic       is_close;

    line_length_d = line_length_q;
    phase_d       = phase_q;
    high_nib_d    = high_nib_q;
    start_ok_d    = start_ok_q;
    hex_bad_d     = hex_bad_q;
    pending_d     = pending_q;
    sum_d         = sum_q;
    count_d       = count_q;
    rec_len_d     = rec_len_q;
    rec_addr_d    = rec_addr_q;
    rec_type_d    = rec_type_q;
    size_d        = size_q;
    halted_d      = halted_q;
    close_d       = close_q;
    store_wr_o    = '0;
    ll            = line_length_q;
    n             = pending_q;
    hx            = hex_nibble(item_i.ch);
    b             = {high_nib_q, hx[3:0]};
    is_close      = (item_i.ch == CharLf) || (item_i.ch == CharCr && item_i.end_of_stream);

    if (accept && !halted_q) begin
      if (is_close) begin
        pending_d = 8'd0;
        close_d   = 1'b1;
      end else if (item_i.ch == CharCr) begin
        pending_d = sat_add8(pending_q, 8'd1);
      end else begin
        pending_d = 8'd0;
        if (n != 8'd0 && ll == 8'd0) begin
          ll         = 8'd1;
          start_ok_d = 1'b0;
          n          = n - 8'd1;
        end
        if (n != 8'd0) begin
          ll        = sat_add8(ll, n);
          phase_d   = phase_d ^ n[0];
          hex_bad_d = 1'b1;
        end
        if (ll == 8'd0) begin
          start_ok_d = (item_i.ch == CharColon);
          ll         = 8'd1;
        end else begin
          ll = sat_add8(ll, 8'd1);
          if (!hx[4]) begin
            hex_bad_d = 1'b1;
          end
          if (!phase_d) begin
            high_nib_d = hx[3:0];
            phase_d    = 1'b1;
          end else begin
            b       = {high_nib_d, hx[3:0]};
            phase_d = 1'b0;
            sum_d   = sum_q + b;
            unique case (count_q)
              8'd0: rec_len_d = b;
              8'd1: rec_addr_d = {b, rec_addr_q[7:0]};
              8'd2: rec_addr_d = {rec_addr_q[15:8], b};
              8'd3: rec_type_d = b;
              default: begin
                if ({1'b0, count_q} < MaxRec9 + 9'd4) begin
                  store_wr_o.en     = 1'b1;
                  store_wr_o.offset = count_q - 8'd4;
                  store_wr_o.data   = b;
                end
              end
            endcase
            count_d = sat_add8(count_q, 8'd1);
          end
        end
        line_length_d = ll;
        if (item_i.end_of_stream) begin
          close_d = 1'b1;
        end
      end
    end

    if (do_close) begin
      close_d       = 1'b0;
      line_length_d = 8'd0;
      phase_d       = 1'b0;
      high_nib_d    = 4'd0;
      start_ok_d    = 1'b0;
      hex_bad_d     = 1'b0;
      pending_d     = 8'd0;
      sum_d         = 8'd0;
      count_d       = 8'd0;
      rec_len_d     = 8'd0;
      rec_addr_d    = 16'd0;
      rec_type_d    = 8'd0;
      if (status == StOk) begin
        size_d = new_size[11:0];
      end else begin
        halted_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= 8'd0;
      phase_q       <= 1'b0;
      high_nib_q    <= 4'd0;
      start_ok_q    <= 1'b0;
      hex_bad_q     <= 1'b0;
      pending_q     <= 8'd0;
      sum_q         <= 8'd0;
      count_q       <= 8'd0;
      rec_len_q     <= 8'd0;
      rec_addr_q    <= 16'd0;
      rec_type_q    <= 8'd0;
      size_q        <= 12'd0;
      halted_q      <= 1'b0;
      close_q       <= 1'b0;
    end else begin
      line_length_q <= line_length_d;
      phase_q       <= phase_d;
      high_nib_q    <= high_nib_d;
      start_ok_q    <= start_ok_d;
      hex_bad_q     <= hex_bad_d;
      pending_q     <= pending_d;
      sum_q         <= sum_d;
      count_q       <= count_d;
      rec_len_q     <= rec_len_d;
      rec_addr_q    <= rec_addr_d;
      rec_type_q    <= rec_type_d;
      size_q        <= size_d;
      halted_q      <= halted_d;
      close_q       <= close_d;
    end
  end

endmodule

// ===== rtl/ihl_queue.sv =====
module ihl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  ihl_pkg::cmd_t wr_cmd_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output ihl_pkg::cmd_t rd_cmd_o,
  output logic          empty_o
);
  import ihl_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_wr;
  logic       do_rd;

  assign full_o   = (count_q == 2'd2);
  assign empty_o  = (count_q == 2'd0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_cmd_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/ihl_back.sv =====
module ihl_back #(
  parameter int unsigned MAX_RECORD_BYTES = ihl_pkg::MaxRecordBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ihl_pkg::store_wr_t store_wr_i,
  input  logic               cmd_empty_i,
  input  ihl_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               busy_o,
  output logic               empty,
  input  logic               pop,
  output ihl_pkg::result_t   result_o
);
  import ihl_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_RECORD_BYTES);

  logic [7:0]  store_mem [MAX_RECORD_BYTES];
  logic [7:0]  rdata_q;

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [7:0]  idx_q, idx_d;
  result_t     out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        last_byte;

  assign out_free  = !out_valid_q || pop;
  assign last_byte = ({1'b0, idx_q} + 9'd1) == {1'b0, cmd_q.len};
  assign empty     = !out_valid_q;
  assign result_o  = out_q;
  assign busy_o    = (state_q != BackIdle);

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_mem[store_wr_i.offset[IdxW-1:0]] <= store_wr_i.data;
    end
    rdata_q <= store_mem[idx_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BackIdle: begin
        if (!cmd_empty_i) begin
          state_d = (cmd_i.is_data && cmd_i.len != 8'd0) ? BackFetch : BackStat;
        end
      end
      BackFetch: state_d = BackEmit;
      BackEmit: begin
        if (out_free) begin
          state_d = last_byte ? BackStat : BackFetch;
        end
      end
      BackStat: begin
        if (out_free) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    cmd_pop_o   = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = 8'd0;
        end
      end
      BackFetch: begin
      end
      BackEmit: begin
        if (out_free) begin
          out_d.kind         = KindWrite;
          out_d.address      = cmd_q.addr + 12'(idx_q);
          out_d.data         = rdata_q;
          out_d.status       = 4'(StOk);
          out_d.program_size = 12'd0;
          out_d.last         = 1'b0;
          out_valid_d        = 1'b1;
          idx_d              = idx_q + 8'd1;
        end
      end
      BackStat: begin
        if (out_free) begin
          out_d.kind         = KindStatus;
          out_d.address      = 12'd0;
          out_d.data         = 8'd0;
          out_d.status       = 4'(cmd_q.status);
          out_d.program_size = cmd_q.size;
          out_d.last         = 1'b1;
          out_valid_d        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
